// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl of the allocation bitmap
// define ASSERT_OFF to compile every check away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge out of reset
`define ABF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen at a clock edge out of reset
`define ABF_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ABF_ASSERT(label, clk, rst_n, prop, msg)
`define ABF_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// File: hw/rtl/abf_pkg.sv
// shared types, constants and helpers of the allocation bitmap
// no dependencies; imported by abf_core and the top level
package abf_pkg;

    localparam int MAX_BITS  = 1024;
    localparam int MAP_BYTES = MAX_BITS / 8;
    localparam int ADDR_W    = $clog2(MAP_BYTES);
    localparam int IDX_W     = $clog2(MAX_BITS);
    localparam int CNT_W     = $clog2(MAX_BITS) + 1;
    localparam int NB_W      = ADDR_W + 1;

    localparam logic [CNT_W-1:0] USED_MAX  = CNT_W'(MAX_BITS);
    localparam logic [7:0]       BYTE_ONES = 8'hFF;
    localparam logic [7:0]       BYTE_ZERO = 8'h00;

    typedef enum logic [2:0] {
        OP_TEST      = 3'd0,
        OP_SET       = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_CLEAR_ALL = 3'd3,
        OP_SET_ALL   = 3'd4,
        OP_FIND_CLR  = 3'd5,
        OP_FIND_SET  = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_DONE
    } state_t;

    // result word, ones_count in the top bits so bit_value lands in bit 0
    typedef struct packed {
        logic [CNT_W-1:0] ones_count;
        logic             all_set;
        logic             all_clear;
        logic [IDX_W-1:0] found_index;
        logic             found;
        logic             bit_value;
    } res_t;

    // position of the lowest set bit of a byte
    function automatic logic [2:0] first_one(input logic [7:0] v);
        logic [2:0] pos;
        pos = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (v[k])
            begin
                pos = 3'(k);
            end
        end
        return pos;
    endfunction

endpackage

// File: hw/rtl/abf_ram.sv
// generic single port synchronous ram, read-first, registered read
// no dependencies
module abf_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/abf_core.sv
// sequencer of the allocation bitmap: read-modify-write of single marks,
// byte scans for finds, per-byte valid bits and the set count; uses abf_pkg, abf_ram
module abf_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  abf_pkg::op_t             op_in,
    input  logic [abf_pkg::IDX_W-1:0] idx_in,
    input  logic                     cfg_clear,
    input  logic [abf_pkg::CNT_W-1:0] used,
    output logic                     res_valid,
    input  logic                     res_ready,
    output abf_pkg::res_t            res
);
    import abf_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               fill_reg, fill_next;
    logic [MAP_BYTES-1:0] valid_reg;
    logic               clr_valid, set_valid;
    op_t                op_reg, op_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]  chk_reg, chk_next;
    logic               bitv_reg, bitv_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   where_reg, where_next;
    logic               valid_q_reg;
    logic               fin;

    logic [ADDR_W-1:0]  ram_addr;
    logic               ram_we;
    logic [7:0]         ram_wdata, ram_rdata;

    logic [NB_W-1:0]    nbytes;
    logic               in_range;
    logic [7:0]         byte_q, mask, match;
    logic               cur_bit;

    abf_ram #(
        .DEPTH(MAP_BYTES),
        .WIDTH(8)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign nbytes   = used[CNT_W-1:3];
    assign in_range = {1'b0, idx_in} < used;
    // bytes never written since the last wipe read as the fill pattern
    assign byte_q   = valid_q_reg ? ram_rdata : (fill_reg ? BYTE_ONES : BYTE_ZERO);
    assign mask     = 8'b1 << idx_reg[2:0];
    assign cur_bit  = byte_q[idx_reg[2:0]];
    assign match    = (op_reg == OP_FIND_SET) ? byte_q : ~byte_q;

    // state register and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            fill_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_clear)
            begin
                count_reg <= '0;
                fill_reg  <= 1'b0;
                valid_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
                fill_reg  <= fill_next;
                if (clr_valid)
                begin
                    valid_reg <= '0;
                end
                else if (set_valid)
                begin
                    valid_reg[idx_reg[IDX_W-1:3]] <= 1'b1;
                end
            end
        end
    end

    // working registers of the current word
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        chk_reg     <= chk_next;
        bitv_reg    <= bitv_next;
        found_reg   <= found_next;
        where_reg   <= where_next;
        valid_q_reg <= valid_reg[ram_addr];
    end

    // next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        fill_next  = fill_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        chk_next   = chk_reg;
        bitv_next  = bitv_reg;
        found_next = found_reg;
        where_next = where_reg;
        clr_valid  = 1'b0;
        set_valid  = 1'b0;
        ram_addr   = idx_in[IDX_W-1:3];
        ram_we     = 1'b0;
        ram_wdata  = byte_q;
        fin        = 1'b0;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = op_in;
                    idx_next   = idx_in;
                    bitv_next  = 1'b0;
                    found_next = 1'b0;
                    where_next = '0;
                    unique case (op_in)
                        OP_TEST, OP_SET, OP_CLEAR:
                        begin
                            if (in_range)
                            begin
                                state_next = ST_RMW;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        OP_CLEAR_ALL:
                        begin
                            clr_valid  = 1'b1;
                            fill_next  = 1'b0;
                            count_next = '0;
                            fin        = 1'b1;
                        end
                        OP_SET_ALL:
                        begin
                            clr_valid  = 1'b1;
                            fill_next  = 1'b1;
                            count_next = used;
                            fin        = 1'b1;
                        end
                        OP_FIND_CLR, OP_FIND_SET:
                        begin
                            ram_addr = '0;
                            chk_next = '0;
                            if (nbytes == '0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_RMW:
            begin
                // modify the byte read last cycle and write it back
                ram_addr  = idx_reg[IDX_W-1:3];
                ram_we    = 1'b1;
                set_valid = 1'b1;
                bitv_next = cur_bit;
                if (op_reg == OP_SET)
                begin
                    ram_wdata = byte_q | mask;
                    if (!cur_bit)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if (op_reg == OP_CLEAR)
                begin
                    ram_wdata = byte_q & ~mask;
                    if (cur_bit)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                fin = 1'b1;
            end
            ST_SCAN:
            begin
                // check the byte that arrived while fetching the next one
                ram_addr = chk_reg + ADDR_W'(1);
                if (match != BYTE_ZERO)
                begin
                    found_next = 1'b1;
                    where_next = {chk_reg, first_one(match)};
                    fin        = 1'b1;
                end
                else if ({1'b0, chk_reg} == NB_W'(nbytes - NB_W'(1)))
                begin
                    fin = 1'b1;
                end
                else
                begin
                    chk_next = chk_reg + ADDR_W'(1);
                end
            end
            ST_DONE:
            begin
                ram_addr = idx_reg[IDX_W-1:3];
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hand the result on, or hold it until the output side is free
        res_valid = fin || (state_reg == ST_DONE);
        if (res_valid)
        begin
            state_next = res_ready ? ST_IDLE : ST_DONE;
        end
    end

    // result fields as they stand after the operation
    always_comb
    begin
        res.bit_value   = bitv_next;
        res.found       = found_next;
        res.found_index = where_next;
        res.all_clear   = (count_next == '0);
        res.all_set     = (count_next == used);
        res.ones_count  = count_next;
    end

endmodule

// File: hw/rtl/allocation_bitmap_find_first.sv
// allocation bitmap with find-first-clear and find-first-set
// uses abf_pkg, abf_core, abf_ram and assert_macros.svh
// input words on s_*: operation and bit_index; one result word per input on m_*.
// the user writes bits_in_use through cfg_we/cfg_data only while the block is
// idle; the block itself does not enforce this. the write wipes every mark and
// the count. reset gives 1024 marks in use, all clear. the marks sit in a
// 128 x 8 ram, one byte per read; the per-byte valid bits are cleared at once
// by reset, a size write, clear all and set all, so no clearing pass. test,
// set and clear in range read the ram, then modify and write back; clear all,
// set all, unused codes and out-of-range bits end in the cycle they are taken.
// a find reads one byte a cycle from byte 0 up to the first match or the last
// byte in use. a result enters the output register, which drives m_tvalid, when free.
// a stalled m_tready holds the word in the output register while the next
// input is taken; a second result then waits inside the core, s_tready low.
`include "assert_macros.svh"
module allocation_bitmap_find_first (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operation[2:0], bit_index[12:3], zero[15:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    // bit_value[0], found[1], found_index[11:2], all_clear[12], all_set[13],
    // ones_count[24:14], zero[31:25]
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data   // bits_in_use
);
    import abf_pkg::*;

    localparam int RES_W = $bits(res_t);

    logic [CNT_W-1:0] bits_in_use_reg;
    logic [CNT_W-1:0] used_raw, used;
    logic             core_valid, core_ready;
    res_t             core_res;
    logic             out_valid_reg;
    res_t             out_res_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_in_use_reg <= USED_MAX;
        end
        else if (cfg_we)
        begin
            bits_in_use_reg <= cfg_data;
        end
    end

    // marks in use, whole bytes, capped at the map size
    assign used_raw = {bits_in_use_reg[CNT_W-1:3], 3'b000};
    assign used     = (used_raw > USED_MAX) ? USED_MAX : used_raw;

    abf_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .op_in    (op_t'(s_tdata[2:0])),
        .idx_in   (s_tdata[IDX_W+2:3]),
        .cfg_clear(cfg_we),
        .used     (used),
        .res_valid(core_valid),
        .res_ready(core_ready),
        .res      (core_res)
    );

    // output register
    assign core_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_ready)
        begin
            out_valid_reg <= core_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_valid && core_ready)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(32 - RES_W)'(0), out_res_reg};

    // checks
    `ABF_ASSERT(a_core_holds, clk, rst_n, core_valid && !core_ready |=> !s_tready, "core took a word while its result was held")
    `ABF_NEVER(a_clear_flag, clk, rst_n, out_valid_reg && (out_res_reg.all_clear != (out_res_reg.ones_count == '0)), "all_clear disagrees with ones_count")
    `ABF_NEVER(a_not_found_zero, clk, rst_n, out_valid_reg && !out_res_reg.found && (out_res_reg.found_index != '0), "found_index set without a match")

endmodule

// File: tb/tb_top.sv
// self-checking testbench for allocation_bitmap_find_first: a scoreboard class tracks the
// mark bytes and the count, predicts every result word and checks the output stream
// depends on abf_pkg and the rtl of allocation_bitmap_find_first
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import abf_pkg::*;

    localparam logic [2:0] OP_UNUSED   = 3'd7;
    localparam int         HOLD_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // operation[2:0], bit_index[12:3], zero[15:13]
    logic        m_tvalid;
    logic        m_tready;
    // bit_value[0], found[1], found_index[11:2], all_clear[12], all_set[13],
    // ones_count[24:14], zero[31:25]
    logic [31:0] m_tdata;
    logic        cfg_we;
    logic [10:0] cfg_data;

    // no random idling on either side while set
    logic        steady;
    // asks the receiver for one long hold-off
    logic        hold_off_req;

    // tracks the marks and the set count, queues the expected result words
    class bitmap_tracker;
        logic [7:0]  marks [MAP_BYTES];
        int unsigned ones;
        logic [10:0] size_reg;
        res_t        expected_results [$];
        int unsigned mismatches;

        function new();
            foreach (marks[n])
                marks[n] = BYTE_ZERO;
            ones       = 0;
            size_reg   = 11'd1024;
            mismatches = 0;
        endfunction

        function int unsigned marks_in_use();
            int unsigned b;
            b = size_reg & 11'h7F8;
            return (b > MAX_BITS) ? MAX_BITS : b;
        endfunction

        // a size write leaves a fresh, empty map
        function void note_config(logic [10:0] value);
            size_reg = value;
            foreach (marks[n])
                marks[n] = BYTE_ZERO;
            ones = 0;
        endfunction

        function void note_request(logic [2:0] op, logic [9:0] idx);
            res_t        r;
            int unsigned used;
            logic [7:0]  m;
            logic [7:0]  v;
            used = marks_in_use();
            r    = '0;
            case (op)
                OP_TEST, OP_SET, OP_CLEAR:
                begin
                    // bits beyond the marks in use read as zero and stay untouched
                    if (idx < used)
                    begin
                        m = 8'd1 << idx[2:0];
                        r.bit_value = |(marks[idx[9:3]] & m);
                        if (op == OP_SET && !r.bit_value)
                        begin
                            marks[idx[9:3]] = marks[idx[9:3]] | m;
                            ones++;
                        end
                        else if (op == OP_CLEAR && r.bit_value)
                        begin
                            marks[idx[9:3]] = marks[idx[9:3]] & ~m;
                            ones--;
                        end
                    end
                end
                OP_CLEAR_ALL:
                begin
                    for (int n = 0; n < used / 8; n++)
                        marks[n] = BYTE_ZERO;
                    ones = 0;
                end
                OP_SET_ALL:
                begin
                    for (int n = 0; n < used / 8; n++)
                        marks[n] = BYTE_ONES;
                    ones = used;
                end
                OP_FIND_CLR, OP_FIND_SET:
                begin
                    // lowest matching bit of the first byte that holds one
                    for (int n = 0; n < used / 8 && !r.found; n++)
                    begin
                        v = (op == OP_FIND_SET) ? marks[n] : ~marks[n];
                        for (int k = 0; k < 8 && !r.found; k++)
                        begin
                            if (v[k])
                            begin
                                r.found       = 1'b1;
                                r.found_index = IDX_W'(n * 8 + k);
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.all_clear  = (ones == 0);
            r.all_set    = (ones == used);
            r.ones_count = CNT_W'(ones);
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected: %h", got);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("bit_value", 16'(want.bit_value), 16'(got.bit_value));
            compare_field("found", 16'(want.found), 16'(got.found));
            compare_field("found_index", 16'(want.found_index), 16'(got.found_index));
            compare_field("all_clear", 16'(want.all_clear), 16'(got.all_clear));
            compare_field("all_set", 16'(want.all_set), 16'(got.all_set));
            compare_field("ones_count", 16'(want.ones_count), 16'(got.ones_count));
        endfunction
    endclass

    bitmap_tracker book = new();

    allocation_bitmap_find_first u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [2:0] rand_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14) return OP_TEST;
        if (r < 36) return OP_SET;
        if (r < 54) return OP_CLEAR;
        if (r < 57) return OP_CLEAR_ALL;
        if (r < 60) return OP_SET_ALL;
        if (r < 78) return OP_FIND_CLR;
        if (r < 97) return OP_FIND_SET;
        return OP_UNUSED;
    endfunction

    // mostly inside the marks in use, sometimes anywhere in the field
    function automatic logic [9:0] rand_index();
        int unsigned used;
        used = book.marks_in_use();
        if (used > 0 && $urandom_range(0, 99) < 85)
            return 10'($urandom_range(0, used - 1));
        return 10'($urandom_range(0, 1023));
    endfunction

    // offer one input word and wait for it to be taken; starts and ends at a falling edge
    task automatic send_request(input logic [2:0] op, input logic [9:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, idx, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        book.note_request(op, idx);
        @(negedge clk);
    endtask

    // size write once every result word is back
    task automatic write_bits_in_use(input logic [10:0] value);
        s_tvalid = 1'b0;
        while (book.expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_data = value;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        book.note_config(value);
    endtask

    task automatic run_random(input int count);
        int         sent;
        int         run_len;
        logic [2:0] fill_op;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // fill or empty the map, punch a few holes, then search both ways
                fill_op = $urandom_range(0, 1) ? OP_SET_ALL : OP_CLEAR_ALL;
                send_request(fill_op, rand_index());
                run_len = $urandom_range(1, 8);
                repeat (run_len)
                    send_request((fill_op == OP_SET_ALL) ? OP_CLEAR : OP_SET, rand_index());
                send_request(OP_FIND_CLR, rand_index());
                send_request(OP_FIND_SET, rand_index());
                sent += run_len + 3;
            end
            else
            begin
                send_request(rand_op(), rand_index());
                sent++;
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        bit held;
        stall_left = 0;
        held       = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !held)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            if (stall_left == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
                m_tready = 1'b1;
        end
    end

    // check every accepted result word
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            book.check_result(res_t'(m_tdata[24:0]));
    end

    // stimulus
    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        steady       = 1'b0;
        hold_off_req = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // full map after reset: edges, repeats, finds hit and miss, unused code
        send_request(OP_TEST, 10'd0);
        send_request(OP_SET, 10'd0);
        send_request(OP_SET, 10'd0);
        send_request(OP_SET, 10'd1023);
        send_request(OP_TEST, 10'd1023);
        send_request(OP_FIND_CLR, 10'd0);
        send_request(OP_FIND_SET, 10'd1023);
        send_request(OP_CLEAR, 10'd0);
        send_request(OP_CLEAR, 10'd0);
        send_request(OP_FIND_SET, 10'd0);
        send_request(OP_SET_ALL, 10'd0);
        send_request(OP_FIND_CLR, 10'd0);
        send_request(OP_CLEAR, 10'd1023);
        send_request(OP_FIND_CLR, 10'd0);
        send_request(OP_CLEAR_ALL, 10'd1023);
        send_request(OP_FIND_SET, 10'd0);
        send_request(OP_UNUSED, 10'd1023);

        // smallest nonempty map: bits past the end and a full byte
        write_bits_in_use(11'd8);
        send_request(OP_SET, 10'd7);
        send_request(OP_TEST, 10'd8);
        send_request(OP_SET_ALL, 10'd0);
        send_request(OP_FIND_CLR, 10'd0);
        send_request(OP_CLEAR, 10'd3);
        send_request(OP_FIND_CLR, 10'd0);

        // no marks in use: finds miss, both status flags high
        write_bits_in_use(11'd7);
        send_request(OP_SET_ALL, 10'd0);
        send_request(OP_FIND_SET, 10'd0);
        send_request(OP_SET, 10'd2);
        send_request(OP_UNUSED, 10'd0);

        write_bits_in_use(11'd1024);
        run_random(180);

        // long receiver hold-off with the sender pushing hard
        write_bits_in_use(11'd96);
        steady       = 1'b1;
        hold_off_req = 1'b1;
        run_random(40);
        steady = 1'b0;
        run_random(90);

        write_bits_in_use(11'd13);
        run_random(90);
        write_bits_in_use(11'd2047);
        run_random(170);
        write_bits_in_use(11'd517);
        run_random(150);
        write_bits_in_use(11'd40);
        run_random(100);
        write_bits_in_use(11'd0);
        run_random(25);
        write_bits_in_use(11'd1031);
        run_random(120);
        write_bits_in_use(11'd256);
        run_random(150);

        // drain
        s_tvalid = 1'b0;
        while (book.expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (book.mismatches == 0)
            $display("[allocation_bitmap_find_first] OK");
        else
            $display("[allocation_bitmap_find_first] ERROR");
        $finish;
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("[allocation_bitmap_find_first] ERROR");
        $finish;
    end

endmodule
